// ===== design/bilinear_source_coordinate_assert.svh =====
// Assertion macros for the checker of the bilinear source coordinate block.
// Self-contained; include it before any assertion is written.
`ifndef BILINEAR_SOURCE_COORDINATE_ASSERT_SVH
`define BILINEAR_SOURCE_COORDINATE_ASSERT_SVH

// Same-cycle implication, masked while reset is high.
`define BSC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, masked while reset is high.
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// Next-cycle implication that is also checked through reset.
`define BSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication through reset");

`endif

// ===== design/bsc_pkg.sv =====
// Types and fixed widths for the bilinear source coordinate block.
// No dependencies; compile before every other file of the block.
package bsc_pkg;

   localparam int DEST_INDEX_W    = 12;
   localparam int ODD_W           = DEST_INDEX_W + 1;
   localparam int TAP_W           = 13;
   localparam int FRAC_W          = 8;
   localparam int DEST_EXTENT_W   = 13;
   localparam int SOURCE_ORIGIN_W = 13;
   localparam int SOURCE_EXTENT_W = 14;
   localparam int CSR_INDEX_W     = 4;
   localparam int CSR_DATA_W      = 14;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEST_EXTENT   = 4'd0,
      CSR_SOURCE_ORIGIN = 4'd1,
      CSR_SOURCE_EXTENT = 4'd2,
      CSR_REVERSE_AXIS  = 4'd3
   } bsc_csr_type;

   // Control carried alongside each word through the divider stages.
   typedef struct packed {
      logic valid;
      logic positive;
   } bsc_tag_type;

endpackage

// ===== design/bilinear_source_coordinate.sv =====
// Bilinear source coordinate generator for one axis of a scaler: top level.
// Depends on bsc_pkg and bsc_div_pipe.
//
// Each word on the req_ channel carries one destination pixel index; the block
// answers with one rsp_ word holding the two source taps (window origin added,
// wrapped to 13 bits) and the 8-bit weight of the second tap, using
// pixel-centre alignment. It takes one word per clock and keeps doing so while
// no stall comes back; latency is MAX_SOURCE-dependent and comes from the
// restoring divider, which resolves one quotient bit per stage of a
// QW = clog2(MAX_SOURCE + 1) + 8 bit quotient, plus a saturation stage, a
// multiply stage, a dividend stage and the output register. Every stage
// holds when the stage ahead of it is full and stalled, so empty slots still
// fill while a result waits on rsp_.
// The csr_ port is always ready; write registers only while no word is in
// flight, since all stages read the live settings.
module bilinear_source_coordinate #(
   parameter int MAX_DEST   = 4096,
   parameter int MAX_SOURCE = 8192
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bsc_pkg::DEST_INDEX_W-1:0]     req_dest_index,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bsc_pkg::TAP_W-1:0]            rsp_first_tap,
   output logic [bsc_pkg::TAP_W-1:0]            rsp_second_tap,
   output logic [bsc_pkg::FRAC_W-1:0]           rsp_tap_fraction,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bsc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import bsc_pkg::*;

   localparam int DW   = $clog2(MAX_DEST + 1);
   localparam int SW   = $clog2(MAX_SOURCE + 1);
   localparam int DVW  = DW + 1;
   localparam int QW   = SW + 8;
   localparam int PW   = ODD_W + SW;
   localparam int XW   = PW + DW + 9;
   localparam int DEW  = (DEST_EXTENT_W > DW) ? DEST_EXTENT_W : DW;
   localparam int SEW  = (SOURCE_EXTENT_W > SW) ? SOURCE_EXTENT_W : SW;
   localparam int DIW  = (DEST_INDEX_W > DW) ? DEST_INDEX_W : DW;
   localparam int SUMW = (SW > TAP_W) ? SW : TAP_W;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DEST_EXTENT_W-1:0]   dest_extent_ff;
   logic [SOURCE_ORIGIN_W-1:0] source_origin_ff;
   logic [SOURCE_EXTENT_W-1:0] source_extent_ff;
   logic                       reverse_axis_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_extent_ff   <= DEST_EXTENT_W'(1);
         source_origin_ff <= '0;
         source_extent_ff <= SOURCE_EXTENT_W'(1);
         reverse_axis_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEST_EXTENT:   dest_extent_ff   <= csr_data[DEST_EXTENT_W-1:0];
            CSR_SOURCE_ORIGIN: source_origin_ff <= csr_data[SOURCE_ORIGIN_W-1:0];
            CSR_SOURCE_EXTENT: source_extent_ff <= csr_data[SOURCE_EXTENT_W-1:0];
            CSR_REVERSE_AXIS:  reverse_axis_ff  <= csr_data[0];
            default: ; // drop writes beyond the register list
         endcase
      end
   end

   // Extents as used: zero reads as one, anything above the maximum clamps.
   logic [DW-1:0] dest_eff;
   logic [SW-1:0] source_eff;
   logic [SW-1:0] source_last;

   always_comb begin
      priority if (dest_extent_ff == '0) begin
         dest_eff = DW'(1);
      end else if (DEW'(dest_extent_ff) > DEW'(MAX_DEST)) begin
         dest_eff = DW'(MAX_DEST);
      end else begin
         dest_eff = DW'(dest_extent_ff);
      end

      priority if (source_extent_ff == '0) begin
         source_eff = SW'(1);
      end else if (SEW'(source_extent_ff) > SEW'(MAX_SOURCE)) begin
         source_eff = SW'(MAX_SOURCE);
      end else begin
         source_eff = SW'(source_extent_ff);
      end
   end

   assign source_last = source_eff - SW'(1);

   // ---------------------------------------------------------------------
   // Flow control: each stage advances when empty or when the next one does
   // ---------------------------------------------------------------------
   logic a_valid_ff, b_valid_ff;
   bsc_tag_type c_tag_ff;
   bsc_tag_type div_tag;
   logic div_ready;
   logic en_a, en_b, en_c, en_out;
   logic rsp_valid_ff;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en_c      = !c_tag_ff.valid || div_ready;
   assign en_b      = !b_valid_ff || en_c;
   assign en_a      = !a_valid_ff || en_b;
   assign req_stall = !en_a;

   // ---------------------------------------------------------------------
   // Stage A: saturate the index, form 2d+1
   // ---------------------------------------------------------------------
   logic [DW-1:0]           dest_limit;
   logic [DEST_INDEX_W-1:0] index_sat;
   logic [ODD_W-1:0]        a_odd_ff;

   assign dest_limit = dest_eff - DW'(1);

   always_comb begin
      if (DIW'(req_dest_index) > DIW'(dest_limit)) begin
         index_sat = DEST_INDEX_W'(dest_limit);
      end else begin
         index_sat = req_dest_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en_a) begin
         a_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_odd_ff <= {index_sat, 1'b1};
      end
   end

   // ---------------------------------------------------------------------
   // Stage B: (2d+1) * S
   // ---------------------------------------------------------------------
   logic [PW-1:0] b_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en_b) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_prod_ff <= PW'(a_odd_ff) * PW'(source_eff);
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: n = prod - D, dividend 256n + D. One division by 2D then gives
   // 256q + fraction, the rounding carry into the tap included.
   // ---------------------------------------------------------------------
   logic                  prod_above;
   logic [PW-1:0]         n_value;
   logic [XW-1:0]         x_wide;
   logic [DVW+QW-1:0]     c_dividend_ff;
   logic [DVW-1:0]        divisor;
   bsc_tag_type           c_tag_in;

   assign prod_above = (b_prod_ff > PW'(dest_eff));
   assign n_value    = b_prod_ff - PW'(dest_eff);
   assign x_wide     = (XW'(n_value) << 8) + XW'(dest_eff);
   assign divisor    = {dest_eff, 1'b0};

   always_comb begin
      c_tag_in.valid    = b_valid_ff;
      c_tag_in.positive = prod_above;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_tag_ff.valid <= 1'b0;
      end else if (en_c) begin
         c_tag_ff <= c_tag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_dividend_ff <= prod_above ? x_wide[DVW+QW-1:0] : '0;
      end
   end

   // ---------------------------------------------------------------------
   // Divider stages
   // ---------------------------------------------------------------------
   logic [QW-1:0] div_quotient;

   bsc_div_pipe #(
      .QW  (QW),
      .DVW (DVW)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .in_tag       (c_tag_ff),
      .in_dividend  (c_dividend_ff),
      .divisor      (divisor),
      .in_ready     (div_ready),
      .out_tag      (div_tag),
      .out_quotient (div_quotient),
      .out_ready    (en_out)
   );

   // ---------------------------------------------------------------------
   // Output stage: clamp, mirror, add origin
   // ---------------------------------------------------------------------
   logic [SW-1:0]     tap_base;
   logic [FRAC_W-1:0] frac_raw;
   logic [SW-1:0]     first_win, second_win;
   logic [SW-1:0]     first_dir, second_dir;
   logic [FRAC_W-1:0] frac_sel;
   logic [SUMW-1:0]   first_sum, second_sum;
   logic [TAP_W-1:0]  rsp_first_tap_ff, rsp_second_tap_ff;
   logic [FRAC_W-1:0] rsp_tap_fraction_ff;

   assign tap_base = div_quotient[QW-1:FRAC_W];
   assign frac_raw = div_quotient[FRAC_W-1:0];

   always_comb begin
      priority if (!div_tag.positive) begin
         // centre falls before the first source pixel
         first_win  = '0;
         second_win = '0;
         frac_sel   = '0;
      end else if (tap_base >= source_last) begin
         // centre at or past the last source pixel
         first_win  = source_last;
         second_win = source_last;
         frac_sel   = '0;
      end else begin
         first_win  = tap_base;
         second_win = tap_base + SW'(1);
         frac_sel   = frac_raw;
      end

      if (reverse_axis_ff) begin
         first_dir  = source_last - first_win;
         second_dir = source_last - second_win;
      end else begin
         first_dir  = first_win;
         second_dir = second_win;
      end

      first_sum  = SUMW'(source_origin_ff) + SUMW'(first_dir);
      second_sum = SUMW'(source_origin_ff) + SUMW'(second_dir);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= div_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_first_tap_ff    <= first_sum[TAP_W-1:0];
         rsp_second_tap_ff   <= second_sum[TAP_W-1:0];
         rsp_tap_fraction_ff <= frac_sel;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_first_tap    = rsp_first_tap_ff;
   assign rsp_second_tap   = rsp_second_tap_ff;
   assign rsp_tap_fraction = rsp_tap_fraction_ff;

endmodule

// ===== design/bsc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with elastic flow.
// Depends on bsc_pkg for the tag type.
module bsc_div_pipe #(
   parameter int QW  = 22,
   parameter int DVW = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bsc_pkg::bsc_tag_type  in_tag,
   input  logic [DVW+QW-1:0]     in_dividend,
   input  logic [DVW-1:0]        divisor,
   output logic                  in_ready,
   output bsc_pkg::bsc_tag_type  out_tag,
   output logic [QW-1:0]         out_quotient,
   input  logic                  out_ready
);
   import bsc_pkg::*;

   bsc_tag_type      tag_ff [QW];
   logic [DVW-1:0]   rem_ff [QW];
   logic [QW-1:0]    low_ff [QW];
   logic [QW-1:0]    quo_ff [QW];
   logic [QW:0]      enable;

   assign enable[QW] = out_ready;

   for (genvar i = 0; i < QW; i++) begin : g_stage
      bsc_tag_type    prev_tag;
      logic [DVW-1:0] prev_rem;
      logic [QW-1:0]  prev_low;
      logic [QW-1:0]  prev_quo;
      logic [DVW:0]   rem_wide;
      logic [DVW:0]   diff;
      logic           take;
      logic [DVW-1:0] rem_in;
      logic [QW-1:0]  low_in;
      logic [QW-1:0]  quo_in;

      if (i == 0) begin : g_head
         assign prev_tag = in_tag;
         assign prev_rem = in_dividend[DVW+QW-1:QW];
         assign prev_low = in_dividend[QW-1:0];
         assign prev_quo = '0;
      end else begin : g_body
         assign prev_tag = tag_ff[i-1];
         assign prev_rem = rem_ff[i-1];
         assign prev_low = low_ff[i-1];
         assign prev_quo = quo_ff[i-1];
      end

      // Bring down the next dividend bit and try the subtraction.
      assign rem_wide = {prev_rem, prev_low[QW-1]};
      assign diff     = rem_wide - {1'b0, divisor};
      assign take     = (rem_wide >= {1'b0, divisor});
      assign rem_in   = take ? diff[DVW-1:0] : rem_wide[DVW-1:0];
      assign low_in   = {prev_low[QW-2:0], 1'b0};
      assign quo_in   = {prev_quo[QW-2:0], take};

      // Advance when empty or when the stage ahead moves.
      assign enable[i] = !tag_ff[i].valid || enable[i+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i].valid <= 1'b0;
         end else if (enable[i]) begin
            tag_ff[i] <= prev_tag;
         end
      end

      always_ff @(posedge clock) begin
         if (enable[i]) begin
            rem_ff[i] <= rem_in;
            low_ff[i] <= low_in;
            quo_ff[i] <= quo_in;
         end
      end
   end

   assign in_ready     = enable[0];
   assign out_tag      = tag_ff[QW-1];
   assign out_quotient = quo_ff[QW-1];

endmodule

// ===== design/bsc_checker.sv =====
// Port-level checker for bilinear_source_coordinate, bound to the top level.
// Depends on bsc_pkg and bilinear_source_coordinate_assert.svh.
`include "bilinear_source_coordinate_assert.svh"

module bsc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [bsc_pkg::TAP_W-1:0]        rsp_first_tap,
   input logic [bsc_pkg::TAP_W-1:0]        rsp_second_tap,
   input logic [bsc_pkg::FRAC_W-1:0]       rsp_tap_fraction,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [bsc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [bsc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bsc_pkg::*;

   logic [7:0]                   inflight_ff, inflight_in;
   logic                         reverse_ff;
   logic [TAP_W-1:0]             tap_step;
   logic [2*TAP_W+FRAC_W-1:0]    rsp_word;
   logic                         rsp_held;
   logic                         blended;

   // Track words in flight from the two handshakes.
   always_comb begin
      inflight_in = inflight_ff;
      if (req_valid && !req_stall) begin
         inflight_in = inflight_in + 8'd1;
      end
      if (rsp_valid && !rsp_stall) begin
         inflight_in = inflight_in - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         reverse_ff  <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         if (csr_valid && csr_ready && (csr_index == CSR_REVERSE_AXIS)) begin
            reverse_ff <= csr_data[0];
         end
      end
   end

   // Interpolating taps sit one apart, in the mirrored direction when reversed.
   assign tap_step = reverse_ff ? (rsp_first_tap - rsp_second_tap)
                                : (rsp_second_tap - rsp_first_tap);

   assign rsp_word = {rsp_first_tap, rsp_second_tap, rsp_tap_fraction};
   assign rsp_held = rsp_valid && rsp_stall;
   assign blended  = rsp_valid && (rsp_tap_fraction != '0);

   `BSC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_word))
   `BSC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)
   `BSC_ASSERT_IMPLIES(a_no_orphan, clock, reset, rsp_valid, inflight_ff != 8'd0)
   `BSC_ASSERT_IMPLIES(a_tap_step, clock, reset, blended, tap_step == TAP_W'(1))

endmodule

bind bilinear_source_coordinate bsc_checker u_bsc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_first_tap    (rsp_first_tap),
   .rsp_second_tap   (rsp_second_tap),
   .rsp_tap_fraction (rsp_tap_fraction),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready),
   .csr_index        (csr_index),
   .csr_data         (csr_data)
);
